// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the frame checker RTL.
// Each macro places one labeled concurrent assertion clocked on clk with
// synchronous reset rst disabling the check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/rfcc_pkg.sv =====
// ---------------------------------------------------------------------------
// rfcc_pkg
// Types, constants and the byte-wide CRC-16 (0x8005) update for the
// response frame checker.
// ---------------------------------------------------------------------------
package rfcc_pkg;

  localparam logic [15:0] CRC_POLY     = 16'h8005;
  localparam logic [7:0]  MAX_EXPECTED = 8'd252;
  localparam logic [7:0]  EXP_LEN_RST  = 8'd4;
  // count byte plus two CRC bytes
  localparam logic [8:0]  FRAME_EXTRA  = 9'd3;

  // one result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_payload;
    logic       frame_done;
    logic       length_error;
    logic       crc_error;
  } rfcc_result_t;

  // CRC update over one byte, data bits taken LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    logic        top;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      top = c[15];
      c   = {c[14:0], 1'b0};
      if (data[i] != top) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/rfcc_frame_core.sv =====
// ---------------------------------------------------------------------------
// rfcc_frame_core
// Frame tracking state and per-byte checks: position, count byte, running
// CRC and CRC compare flags. Result is combinational from the current byte.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rfcc_frame_core
  import rfcc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   data,
  input  logic [7:0]   expected_len,
  output rfcc_result_t result
);

  logic [7:0]  byte_position;
  logic [7:0]  count_seen;
  logic [15:0] crc_value;
  logic        crc_low_ok;
  logic        crc_compared;

  logic [7:0]  byte_position_next;
  logic [7:0]  count_seen_next;
  logic [15:0] crc_value_next;
  logic        crc_low_ok_next;
  logic        crc_compared_next;

  logic [7:0]  elen;
  logic [8:0]  flen;
  logic [7:0]  cnt;
  logic [8:0]  pos_p1;
  logic [8:0]  pos_p2;
  logic        cnt_ok;
  logic        done;
  logic        low_ok_w;
  logic        compared_w;
  logic [15:0] crc_w;

  // Per-byte evaluation
  always_comb begin
    elen   = (expected_len > MAX_EXPECTED) ? MAX_EXPECTED : expected_len;
    flen   = {1'b0, elen} + FRAME_EXTRA;
    cnt    = (byte_position == '0) ? data : count_seen;
    cnt_ok = (cnt >= 8'd3) && ({1'b0, cnt} <= flen);
    pos_p1 = {1'b0, byte_position} + 9'd1;
    pos_p2 = {1'b0, byte_position} + 9'd2;

    crc_w = (pos_p2 < {1'b0, cnt}) ? crc_byte(crc_value, data) : crc_value;

    low_ok_w   = crc_low_ok;
    compared_w = crc_compared;
    if (cnt_ok && (pos_p2 == {1'b0, cnt})) begin
      low_ok_w = (data == crc_value[7:0]);
    end
    if (cnt_ok && (pos_p1 == {1'b0, cnt})) begin
      low_ok_w   = crc_low_ok && (data == crc_value[15:8]);
      compared_w = 1'b1;
    end

    done = (pos_p1 >= flen);

    result.out_byte     = data;
    result.is_payload   = (byte_position >= 8'd1) && (byte_position <= elen);
    result.frame_done   = done;
    result.length_error = done && ({1'b0, cnt} != flen);
    result.crc_error    = done && !(cnt_ok && compared_w && low_ok_w);
  end

  // Next state: rearm after the last byte
  always_comb begin
    if (done) begin
      byte_position_next = '0;
      count_seen_next    = '0;
      crc_value_next     = '0;
      crc_low_ok_next    = 1'b0;
      crc_compared_next  = 1'b0;
    end else begin
      byte_position_next = pos_p1[7:0];
      count_seen_next    = cnt;
      crc_value_next     = crc_w;
      crc_low_ok_next    = low_ok_w;
      crc_compared_next  = compared_w;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      count_seen    <= '0;
      crc_value     <= '0;
      crc_low_ok    <= 1'b0;
      crc_compared  <= 1'b0;
    end else if (step) begin
      byte_position <= byte_position_next;
      count_seen    <= count_seen_next;
      crc_value     <= crc_value_next;
      crc_low_ok    <= crc_low_ok_next;
      crc_compared  <= crc_compared_next;
    end
  end

  `ASSERT_NEXT(a_rearm, clk, rst, step && result.frame_done, byte_position == '0)
  `ASSERT_NEXT(a_hold, clk, rst, !step, $stable(byte_position) && $stable(crc_value))
  `ASSERT_IMPLIES(a_flags_last, clk, rst, result.length_error || result.crc_error,
                  result.frame_done)

endmodule

// ===== rtl/response_frame_crc_checker_unit.sv =====
// ---------------------------------------------------------------------------
// response_frame_crc_checker_unit
// Checks received response frames (count byte, payload, CRC-16 low/high)
// byte by byte and passes every byte through with frame status.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, rx_byte): one frame byte per item,
//   count byte first. Output channel (out_valid/out_ready): one result item
//   per input item with the byte, a payload mark, and on the last byte of a
//   frame the length and CRC verdicts.
//   Config channel (cfg_valid/cfg_ready, cfg_data): sets expected_len, the
//   number of payload bytes (values above 252 act as 252); a frame is expected_len+3
//   bytes. Write it only while no item is in flight. cfg_ready is always high.
// Path: an accepted item enters the input register, then passes the CRC/compare
//   logic into the result register, which raises out_valid.
// Throughput: one item per cycle while the receiver keeps out_ready high; the byte-wide
//   CRC update is the longest path between the two registers.
// Reset: frame state clears, expected_len returns to 4, both stages empty.
// Receiver stall: the result register holds; the input register still takes
//   one more item, then in_ready drops until the result is taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module response_frame_crc_checker_unit
  import rfcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  // input bytes
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  // results
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       is_payload,
  output logic       frame_done,
  output logic       length_error,
  output logic       crc_error
);

  logic [7:0]   expected_len;
  logic         stage_valid;
  logic [7:0]   stage_byte;
  logic         stage_adv;
  logic         out_free;
  rfcc_result_t core_result;
  rfcc_result_t result_q;

  assign cfg_ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_len <= EXP_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      expected_len <= cfg_data;
    end
  end

  // Handshake
  assign out_free  = !out_valid || out_ready;
  assign stage_adv = stage_valid && out_free;
  assign in_ready  = !stage_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= rx_byte;
    end
  end

  rfcc_frame_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (stage_adv),
    .data         (stage_byte),
    .expected_len (expected_len),
    .result       (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv) begin
      result_q <= core_result;
    end
  end

  assign out_byte     = result_q.out_byte;
  assign is_payload   = result_q.is_payload;
  assign frame_done   = result_q.frame_done;
  assign length_error = result_q.length_error;
  assign crc_error    = result_q.crc_error;

  `ASSERT_NEXT(a_stage_keep, clk, rst, stage_valid && !stage_adv, stage_valid)
  `ASSERT_NEXT(a_adv_fills, clk, rst, stage_adv, out_valid)
  `ASSERT_IMPLIES(a_ready_stall, clk, rst, stage_valid && out_valid && !out_ready, !in_ready)

endmodule

// ===== bench/tb_response_frame_crc_checker_unit.sv =====
// ---------------------------------------------------------------------------
// tb_response_frame_crc_checker_unit
// Self-checking bench for the response frame checker. Frames (count byte,
// payload, CRC-16 low/high) are built and pushed one byte per item. The
// expected status of every byte is predicted on the fly and compared with
// each result item as it is taken.
// ---------------------------------------------------------------------------
module tb_response_frame_crc_checker_unit
  import rfcc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 240;

  typedef enum int {
    FRAME_GOOD,
    FRAME_CORRUPT,
    FRAME_SHORT_COUNT,
    FRAME_BAD_COUNT,
    FRAME_NOISE
  } frame_kind_t;

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       is_payload;
  logic       frame_done;
  logic       length_error;
  logic       crc_error;

  // predictor copy of the register and frame state
  logic [7:0]  cur_expected_len = EXP_LEN_RST;
  logic [7:0]  frame_pos        = '0;
  logic [7:0]  frame_count      = '0;
  logic [15:0] frame_crc        = '0;
  logic        crc_lo_match     = 1'b0;
  logic        crc_hi_seen      = 1'b0;

  rfcc_result_t predicted_status[$];
  logic [7:0]   frame_bytes[$];

  // traffic shaping knobs
  bit          send_gaps = 1'b0;
  bit          stall_on  = 1'b0;
  int unsigned hold_left = 0;
  int unsigned burst_left = 0;

  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned frames_ended  = 0;
  int unsigned len_errs_seen = 0;
  int unsigned crc_errs_seen = 0;
  int unsigned cfg_writes    = 0;
  int unsigned mismatches    = 0;

  response_frame_crc_checker_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .is_payload   (is_payload),
    .frame_done   (frame_done),
    .length_error (length_error),
    .crc_error    (crc_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // CRC-16/0x8005 over one byte, data bits LSB first
  function automatic logic [15:0] crc16_8005_byte(input logic [15:0] crc_in,
                                                  input logic [7:0]  data);
    logic [15:0] c;
    logic        fb;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb = data[i] ^ c[15];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // whole frame length for the current setting; large settings clamp
  function automatic int frame_length();
    int eff;
    eff = (cur_expected_len > MAX_EXPECTED) ? MAX_EXPECTED : cur_expected_len;
    return eff + 3;
  endfunction

  // expected status of one accepted byte; advances the frame state
  task automatic predict_byte_status(input logic [7:0] b);
    rfcc_result_t r;
    int           flen;
    int           p;
    int           cnt;
    logic         cnt_ok;
    logic         done;
    flen = frame_length();
    p    = frame_pos;
    if (p == 0) begin
      frame_count = b;
    end
    cnt    = frame_count;
    cnt_ok = (cnt >= 3) && (cnt <= flen);
    if (p + 2 < cnt) begin
      frame_crc = crc16_8005_byte(frame_crc, b);
    end
    if (cnt_ok && (p + 2 == cnt)) begin
      crc_lo_match = (b == frame_crc[7:0]);
    end
    if (cnt_ok && (p + 1 == cnt)) begin
      crc_lo_match = crc_lo_match && (b == frame_crc[15:8]);
      crc_hi_seen  = 1'b1;
    end
    done           = (p + 1 >= flen);
    r.out_byte     = b;
    r.is_payload   = (p >= 1) && (p <= flen - 3);
    r.frame_done   = done;
    r.length_error = done && (cnt != flen);
    r.crc_error    = done && !(cnt_ok && crc_hi_seen && crc_lo_match);
    predicted_status.push_back(r);
    if (done) begin
      frame_pos    = '0;
      frame_count  = '0;
      frame_crc    = '0;
      crc_lo_match = 1'b0;
      crc_hi_seen  = 1'b0;
    end else begin
      frame_pos = 8'(p + 1);
    end
  endtask

  // offer one byte, with random gaps between bursts when send_gaps is set
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = send_gaps ? $urandom_range(0, 6) : 0;
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    predict_byte_status(b);
  endtask

  // sender pause: stop offering until every predicted result is taken
  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_expected_len(input logic [7:0] v);
    wait_all_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_expected_len = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // fill frame_bytes with one frame of the given kind for the current length
  task automatic build_frame(input frame_kind_t kind, input int fill);
    int          flen;
    int          cnt;
    int          crc_at;
    int          idx;
    logic [15:0] c;
    flen = frame_length();
    frame_bytes = {};
    for (int i = 0; i < flen; i++) begin
      frame_bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    end
    case (kind)
      FRAME_SHORT_COUNT: begin
        cnt = $urandom_range(3, flen);
      end
      FRAME_BAD_COUNT: begin
        if (flen == 255 || $urandom_range(0, 1) == 0) begin
          cnt = $urandom_range(0, 2);
        end else begin
          cnt = $urandom_range(flen + 1, 255);
        end
      end
      FRAME_NOISE: begin
        cnt = $urandom_range(0, 255);
      end
      default: begin
        cnt = flen;
      end
    endcase
    frame_bytes[0] = 8'(cnt);
    // noise frames carry no CRC at all
    if (kind != FRAME_NOISE) begin
      crc_at = (kind == FRAME_SHORT_COUNT) ? cnt : flen;
      c = '0;
      for (int i = 0; i < crc_at - 2; i++) begin
        c = crc16_8005_byte(c, frame_bytes[i]);
      end
      frame_bytes[crc_at - 2] = c[7:0];
      frame_bytes[crc_at - 1] = c[15:8];
      if (kind == FRAME_CORRUPT) begin
        idx = crc_at - 2 + $urandom_range(0, 1);
        frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
      end
    end
  endtask

  task automatic send_frame(input frame_kind_t kind, input int fill);
    build_frame(kind, fill);
    foreach (frame_bytes[i]) begin
      send_byte(frame_bytes[i]);
    end
  endtask

  // ---- tests ----

  // default length of four right after reset
  task automatic test_reset_default();
    send_frame(FRAME_GOOD, 8'h00);
    send_frame(FRAME_BAD_COUNT, -1);
  endtask

  // zero and one byte payloads, bad counts and bad CRC
  task automatic test_extreme_lengths();
    write_expected_len(8'd0);
    send_frame(FRAME_GOOD, -1);
    send_frame(FRAME_BAD_COUNT, -1);
    write_expected_len(8'd1);
    send_frame(FRAME_CORRUPT, 8'hff);
    send_frame(FRAME_SHORT_COUNT, -1);
  endtask

  // length changed with a frame half received
  task automatic test_midframe_config();
    write_expected_len(8'd253);
    build_frame(FRAME_GOOD, -1);
    for (int i = 0; i < 6; i++) begin
      send_byte(frame_bytes[i]);
    end
    // next offset is already past the new last offset: this byte ends it
    write_expected_len(8'd2);
    send_byte(8'h5a);
    send_frame(FRAME_GOOD, -1);
    // growing the length stretches the current frame
    build_frame(FRAME_GOOD, -1);
    send_byte(frame_bytes[0]);
    send_byte(frame_bytes[1]);
    write_expected_len(8'd9);
    repeat (10) send_byte(8'($urandom));
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    write_expected_len(8'd5);
    send_gaps = 1'b0;
    stall_on  = 1'b0;
    hold_left = 80;
    repeat (4) send_frame(FRAME_GOOD, -1);
    wait_all_results();
    send_gaps = 1'b1;
    stall_on  = 1'b1;
    send_frame(FRAME_GOOD, -1);
    send_frame(FRAME_CORRUPT, -1);
  endtask

  // full-size frames
  task automatic test_longest_frames();
    write_expected_len(MAX_EXPECTED);
    send_frame(FRAME_GOOD, -1);
    write_expected_len(8'd255);
    send_frame(FRAME_BAD_COUNT, -1);
  endtask

  // mostly well-formed frames over random small lengths
  task automatic test_random_frames();
    int unsigned start;
    int unsigned sel;
    int unsigned len;
    int unsigned nfr;
    frame_kind_t kind;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        len = 0;
      end else if (sel < 75) begin
        len = $urandom_range(1, 8);
      end else if (sel < 95) begin
        len = $urandom_range(9, 40);
      end else begin
        len = $urandom_range(41, 120);
      end
      write_expected_len(8'(len));
      send_gaps = ($urandom_range(0, 3) != 0);
      stall_on  = ($urandom_range(0, 3) != 0);
      nfr = $urandom_range(2, 8);
      repeat (nfr) begin
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
          kind = FRAME_GOOD;
        end else if (sel < 77) begin
          kind = FRAME_CORRUPT;
        end else if (sel < 87) begin
          kind = FRAME_SHORT_COUNT;
        end else if (sel < 94) begin
          kind = FRAME_BAD_COUNT;
        end else begin
          kind = FRAME_NOISE;
        end
        if ($urandom_range(0, 15) == 0) begin
          hold_left = $urandom_range(20, 60);
        end
        send_frame(kind, -1);
      end
      if ($urandom_range(0, 3) == 0) begin
        wait_all_results();
      end
    end
  endtask

  // receiver: rotating stall pattern, reshuffled now and then, plus hold-offs
  initial begin : receiver
    logic [7:0]  pat;
    int unsigned age;
    out_ready = 1'b0;
    pat = 8'hff;
    age = 0;
    forever begin
      @(negedge clk);
      if (age == 0) begin
        pat = 8'($urandom_range(1, 255));
        age = $urandom_range(16, 80);
      end
      age--;
      pat = {pat[6:0], pat[7]};
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= stall_on ? pat[0] : 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // compare each taken result with the oldest prediction
  always @(posedge clk) begin : result_check
    rfcc_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (predicted_status.size() == 0) begin
        $error("result item with nothing predicted: out_byte %0h", out_byte);
        mismatches++;
      end else begin
        want = predicted_status.pop_front();
        results_seen++;
        check_field("out_byte", want.out_byte, out_byte);
        check_field("is_payload", 8'(want.is_payload), 8'(is_payload));
        check_field("frame_done", 8'(want.frame_done), 8'(frame_done));
        check_field("length_error", 8'(want.length_error), 8'(length_error));
        check_field("crc_error", 8'(want.crc_error), 8'(crc_error));
        if (want.frame_done) frames_ended++;
        if (want.length_error) len_errs_seen++;
        if (want.crc_error) crc_errs_seen++;
      end
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    rx_byte   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_reset_default();
    test_extreme_lengths();
    test_midframe_config();
    test_backpressure();
    test_longest_frames();
    test_random_frames();

    wait_all_results();
    repeat (10) @(posedge clk);
    $display("Checked %0d bytes in %0d frames (%0d length, %0d CRC verdicts flagged),",
             results_seen, frames_ended, len_errs_seen, crc_errs_seen);
    $display("across %0d length settings with sender gaps, receiver stalls and hold-offs.",
             cfg_writes);
    if (mismatches == 0) begin
      $display("tb_response_frame_crc_checker_unit: PASS");
    end else begin
      $display("tb_response_frame_crc_checker_unit: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("tb_response_frame_crc_checker_unit: FAIL");
    $finish;
  end

endmodule
